// ===== hw/rtl/bhpq_pkg.sv =====
// Shared constants, codes and helper functions for the binary heap priority queue.
// No dependencies; every other file of the block except bhpq_ram imports this package.
`default_nettype none

package bhpq_pkg;

	// Store geometry and key width
	localparam int CAPACITY = 256;
	localparam int KEY_BITS = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Configuration port geometry
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Operation codes
	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;

	// Register index of order_mode (byte address bits above the word offset)
	localparam logic REG_ORDER_MODE = 1'b0;

	// Order modes
	localparam logic MODE_MAX = 1'b0;

	// True when a belongs lower in the heap than b under the given mode
	function automatic logic key_below(input logic mode, input logic [KEY_BITS-1:0] a,
		input logic [KEY_BITS-1:0] b);
		logic res;
		if (mode == MODE_MAX) begin
			res = (a < b);
		end else begin
			res = (a > b);
		end
		return res;
	endfunction

	// Map a 1-based heap position to a 0-based memory address
	function automatic logic [ADDR_W-1:0] pos_to_addr(input logic [CNT_W-1:0] pos);
		logic [CNT_W-1:0] zb;
		zb = pos - CNT_W'(1);
		return zb[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bhpq_in_if.sv =====
// Command channel interface of the heap: valid/ready handshake with op and key.
// Depends on bhpq_pkg for the key width.
`default_nettype none

interface bhpq_in_if;
	import bhpq_pkg::*;

	logic                valid;
	logic                ready;
	logic                op;
	logic [KEY_BITS-1:0] key;

	modport source (output valid, output op, output key, input ready);
	modport sink (input valid, input op, input key, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bhpq_out_if.sv =====
// Response channel interface of the heap: valid/ready handshake with result fields.
// Depends on bhpq_pkg for key and count widths.
`default_nettype none

interface bhpq_out_if;
	import bhpq_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [KEY_BITS-1:0] extracted_key;
	logic                top_valid;
	logic [KEY_BITS-1:0] top_key;
	logic [CNT_W-1:0]    entry_count;

	modport source (output valid, output status, output extracted_key, output top_valid,
		output top_key, output entry_count, input ready);
	modport sink (input valid, input status, input extracted_key, input top_valid,
		input top_key, input entry_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bhpq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; sized by its width and depth parameters.
`default_nettype none

module bhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bhpq_cfg.sv =====
// APB-style configuration register file of the heap (order_mode only).
// Depends on bhpq_pkg for address/data widths and register indexes.
`default_nettype none

module bhpq_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [bhpq_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [bhpq_pkg::PDATA_W-1:0]    pwdata,
	output      logic [bhpq_pkg::PDATA_W-1:0]    prdata,
	output      logic                            pready,
	output      logic                            order_mode
);
	import bhpq_pkg::*;

	logic order_mode_q;
	logic wr_en;
	logic reg_sel;

	// Decode the word index; the low address bits are the byte offset
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_ORDER_MODE);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Hold the order mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= MODE_MAX;
		end else if (wr_en && reg_sel) begin
			order_mode_q <= pwdata[0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = {{(PDATA_W-1){1'b0}}, order_mode_q};
		end
	end

	assign order_mode = order_mode_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bhpq_core.sv =====
// Heap sequencer: sifts keys up or down through the key RAM, one level per pass.
// Depends on bhpq_pkg, bhpq_in_if, bhpq_out_if and bhpq_ram.
`default_nettype none

module bhpq_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  order_mode,
	bhpq_in_if.sink    cmd,
	bhpq_out_if.source rsp
);
	import bhpq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP,
		S_UP_CMP,
		S_DN_LAST,
		S_DN,
		S_DN_L,
		S_DN_R,
		S_DN_SWAP,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    pos_q;
	logic [KEY_BITS-1:0] v_q;
	logic [KEY_BITS-1:0] ext_q;
	logic [KEY_BITS-1:0] child_key_q;
	logic [CNT_W-1:0]    child_pos_q;
	logic [1:0]          status_q;
	logic [KEY_BITS-1:0] top_q;

	logic                out_valid_q;
	logic [1:0]          out_status_q;
	logic [KEY_BITS-1:0] out_ext_q;
	logic                out_top_valid_q;
	logic [KEY_BITS-1:0] out_top_key_q;
	logic [CNT_W-1:0]    out_count_q;

	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [KEY_BITS-1:0] wdata;
	logic                re;
	logic [ADDR_W-1:0]   raddr;
	logic [KEY_BITS-1:0] rdata;

	logic                accept;
	logic [CNT_W:0]      left;
	logic [CNT_W:0]      right;
	logic [CNT_W:0]      count_ext;
	logic                out_free;

	bhpq_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign left      = {pos_q, 1'b0};
	assign right     = {pos_q, 1'b1};
	assign count_ext = {1'b0, count_q};
	assign out_free  = !out_valid_q || rsp.ready;

	// Drive RAM accesses; each pass either reads the next entry or writes one back
	always_comb begin
		we    = 1'b0;
		waddr = pos_to_addr(pos_q);
		wdata = v_q;
		re    = 1'b0;
		raddr = pos_to_addr(pos_q);
		case (state_q)
			S_IDLE: begin
				if (accept && cmd.op == OP_EXTRACT && count_q > CNT_W'(1)) begin
					re    = 1'b1;
					raddr = pos_to_addr(count_q);
				end
			end
			S_UP: begin
				if (pos_q == CNT_W'(1)) begin
					we = 1'b1;
				end else begin
					re    = 1'b1;
					raddr = pos_to_addr(pos_q >> 1);
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (key_below(order_mode, rdata, v_q)) begin
					wdata = rdata;
				end
			end
			S_DN: begin
				if (left > count_ext) begin
					we = 1'b1;
				end else begin
					re    = 1'b1;
					raddr = pos_to_addr(left[CNT_W-1:0]);
				end
			end
			S_DN_L: begin
				if (right <= count_ext) begin
					re    = 1'b1;
					raddr = pos_to_addr(right[CNT_W-1:0]);
				end
			end
			S_DN_SWAP: begin
				we = 1'b1;
				if (key_below(order_mode, v_q, child_key_q)) begin
					wdata = child_key_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Mirror the root so the top key needs no extra read
	always_ff @(posedge clk) begin
		if (we && waddr == '0) begin
			top_q <= wdata;
		end
	end

	// Sequence state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.op == OP_INSERT) begin
							ext_q <= '0;
							if (count_q == CNT_W'(CAPACITY)) begin
								status_q <= ST_OVERFLOW;
								state_q  <= S_DONE;
							end else begin
								status_q <= ST_OK;
								count_q  <= count_q + CNT_W'(1);
								pos_q    <= count_q + CNT_W'(1);
								v_q      <= cmd.key;
								state_q  <= S_UP;
							end
						end else begin
							if (count_q == '0) begin
								ext_q    <= '0;
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								status_q <= ST_OK;
								ext_q    <= top_q;
								count_q  <= count_q - CNT_W'(1);
								pos_q    <= CNT_W'(1);
								state_q  <= (count_q == CNT_W'(1)) ? S_DONE : S_DN_LAST;
							end
						end
					end
				end
				S_UP: begin
					state_q <= (pos_q == CNT_W'(1)) ? S_DONE : S_UP_CMP;
				end
				S_UP_CMP: begin
					// Parent moves down into the hole, or the key settles here
					if (key_below(order_mode, rdata, v_q)) begin
						pos_q   <= pos_q >> 1;
						state_q <= S_UP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DN_LAST: begin
					v_q     <= rdata;
					state_q <= S_DN;
				end
				S_DN: begin
					state_q <= (left > count_ext) ? S_DONE : S_DN_L;
				end
				S_DN_L: begin
					child_key_q <= rdata;
					child_pos_q <= left[CNT_W-1:0];
					state_q     <= (right <= count_ext) ? S_DN_R : S_DN_SWAP;
				end
				S_DN_R: begin
					// Right child wins only when strictly better; ties stay left
					if (key_below(order_mode, child_key_q, rdata)) begin
						child_key_q <= rdata;
						child_pos_q <= right[CNT_W-1:0];
					end
					state_q <= S_DN_SWAP;
				end
				S_DN_SWAP: begin
					if (key_below(order_mode, v_q, child_key_q)) begin
						pos_q   <= child_pos_q;
						state_q <= S_DN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Load the result once the output register is free
					if (out_free) begin
						out_valid_q     <= 1'b1;
						out_status_q    <= status_q;
						out_ext_q       <= ext_q;
						out_count_q     <= count_q;
						out_top_valid_q <= (count_q != '0);
						out_top_key_q   <= (count_q != '0) ? top_q : '0;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.extracted_key = out_ext_q;
	assign rsp.top_valid     = out_top_valid_q;
	assign rsp.top_key       = out_top_key_q;
	assign rsp.entry_count   = out_count_q;

endmodule

`default_nettype wire

// ===== hw/rtl/binary_heap_priority_queue.sv =====
// Binary heap priority queue, one operation at a time; each level costs a read, compare, write.
// Insert: the key climbs up to 8 levels, a parent read, compare and write each, until it settles.
// Extract: the last entry is read and sifted down from the root (up to 7 levels); each level
// reads its children, compares, writes. Overflow, empty, single-entry extract: no heap walk.
// Next command is taken the cycle after the result loads; a held result stalls the next load.
// Reset (arst_n low, asynchronous) empties the heap and selects max order; RAM is not cleared.
`default_nettype none

module binary_heap_priority_queue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	bhpq_in_if.sink                           cmd,
	bhpq_out_if.source                        rsp,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [bhpq_pkg::PADDR_W-1:0] paddr,
	input  wire logic [bhpq_pkg::PDATA_W-1:0] pwdata,
	output      logic [bhpq_pkg::PDATA_W-1:0] prdata,
	output      logic                         pready
);
	import bhpq_pkg::*;

	logic order_mode;

	bhpq_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.order_mode (order_mode)
	);

	bhpq_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.order_mode (order_mode),
		.cmd        (cmd),
		.rsp        (rsp)
	);

	// Busy after every accepted command
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command accepted while a previous one is in flight");

	// Top valid tracks a nonzero count
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.top_valid == (rsp.entry_count != '0)))
		else $error("top_valid disagrees with entry_count");

	// Failed operations remove nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.extracted_key == '0)
		else $error("nonzero extracted key on a failed operation");

	// Count never exceeds the store
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.entry_count <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	// Empty heap reports a zero top key
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.top_valid |-> rsp.top_key == '0)
		else $error("nonzero top key on an empty heap");

endmodule

`default_nettype wire
